// ===== rtl/scqc_pkg.sv =====
// shared types, constants and helper functions for the scissor quad clip block
package scqc_pkg;

  localparam int UV_FRAC_BITS = 12;
  localparam int NUM_W        = 34;
  localparam int DIV_W        = 15;
  localparam int AXIS_LAT     = 2 * NUM_W + 4;

  typedef enum logic [1:0] {
    REG_CLIP_LEFT,
    REG_CLIP_TOP,
    REG_CLIP_WIDTH,
    REG_CLIP_HEIGHT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CORNER_TL,
    CORNER_BL,
    CORNER_BR,
    CORNER_TR
  } corner_t;

  typedef struct packed {
    logic              on;
    logic signed [15:0] lo;
    logic [14:0]       len;
  } axis_cfg_t;

  typedef struct packed {
    logic               neg;
    logic               clip;
    logic signed [17:0] d;
    logic signed [15:0] pos;
    logic signed [17:0] size;
    logic signed [15:0] st;
    logic signed [15:0] en;
  } edge_side_t;

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    if (v > 36'sd32767) begin
      return 16'sh7fff;
    end else if (v < -36'sd32768) begin
      return 16'sh8000;
    end else begin
      return $signed(v[15:0]);
    end
  endfunction

  function automatic logic [15:0] to_half(input logic signed [15:0] v);
    logic        sgn;
    logic [16:0] mag;
    logic [4:0]  p;
    logic [16:0] norm;
    logic [11:0] m;
    logic [5:0]  e;
    sgn = v[15];
    mag = sgn ? (~{v[15], v} + 17'd1) : {1'b0, v};
    p = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (mag[i]) p = 5'(i);
    end
    norm = mag << (5'd16 - p);
    m = {1'b0, norm[16:6]} + 12'(norm[5] && ((|norm[4:0]) || norm[6]));
    e = 6'(p) + 6'(15 - UV_FRAC_BITS) + 6'(m[11]);
    if (v == 16'sd0) begin
      return 16'd0;
    end
    return {sgn, e[4:0], (m[11] ? 10'd0 : m[9:0])};
  endfunction

endpackage

// ===== rtl/scqc_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with sideband
module scqc_div #(
  parameter int SIDE_W = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [scqc_pkg::NUM_W-1:0]  in_num,
  input  logic [scqc_pkg::DIV_W-1:0]  in_div,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_vld,
  output logic [scqc_pkg::NUM_W-1:0]  out_quo,
  output logic [SIDE_W-1:0]           out_side
);

  localparam int N = scqc_pkg::NUM_W;
  localparam int D = scqc_pkg::DIV_W;

  logic [N-1:0]      nq_r   [N];
  logic [D-1:0]      rem_r  [N];
  logic [D-1:0]      dv_r   [N];
  logic [SIDE_W-1:0] side_r [N];
  logic              vld_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [N-1:0]      nq_i;
    logic [D-1:0]      rem_i;
    logic [D-1:0]      dv_i;
    logic [SIDE_W-1:0] sd_i;
    logic              v_i;
    logic [D:0]        trial;
    logic              take;

    if (k == 0) begin : g_first
      assign nq_i  = in_num;
      assign rem_i = '0;
      assign dv_i  = in_div;
      assign sd_i  = in_side;
      assign v_i   = in_vld;
    end else begin : g_next
      assign nq_i  = nq_r[k-1];
      assign rem_i = rem_r[k-1];
      assign dv_i  = dv_r[k-1];
      assign sd_i  = side_r[k-1];
      assign v_i   = vld_r[k-1];
    end

    assign trial = {rem_i, nq_i[N-1]};
    assign take  = (trial >= {1'b0, dv_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= take ? D'(trial - {1'b0, dv_i}) : trial[D-1:0];
      nq_r[k]   <= {nq_i[N-2:0], take};
      dv_r[k]   <= dv_i;
      side_r[k] <= sd_i;
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_quo  = nq_r[N-1];
  assign out_side = side_r[N-1];

endmodule

// ===== rtl/scqc_axis.sv =====
// one axis of the clip: near edge then far edge, each with its own divider
module scqc_axis (
  input  logic                    clk,
  input  logic                    rst_n,
  input  scqc_pkg::axis_cfg_t     cfg,
  input  logic                    in_vld,
  input  logic signed [15:0]      in_pos,
  input  logic signed [15:0]      in_size,
  input  logic signed [15:0]      in_st,
  input  logic signed [15:0]      in_en,
  output logic                    out_vld,
  output logic signed [15:0]      out_pos,
  output logic signed [17:0]      out_size,
  output logic signed [15:0]      out_st,
  output logic signed [15:0]      out_en
);

  localparam int SW = $bits(scqc_pkg::edge_side_t);

  // near edge setup
  logic signed [16:0]        d1;
  logic signed [16:0]        sp1;
  logic [16:0]               mag1;
  logic                      e1;
  logic                      a1_vld_r;
  logic [scqc_pkg::NUM_W-1:0] a1_num_r;
  scqc_pkg::edge_side_t      a1_r;
  scqc_pkg::edge_side_t      a1_nxt;

  assign d1   = $signed({cfg.lo[15], cfg.lo}) - $signed({in_pos[15], in_pos});
  assign e1   = cfg.on && (d1 > 17'sd0);
  assign sp1  = $signed({in_en[15], in_en}) - $signed({in_st[15], in_st});
  assign mag1 = sp1[16] ? 17'(-sp1) : 17'(sp1);

  always_comb begin
    a1_nxt.neg  = sp1[16];
    a1_nxt.clip = e1;
    a1_nxt.d    = 18'(d1);
    a1_nxt.pos  = in_pos;
    a1_nxt.size = 18'(in_size);
    a1_nxt.st   = in_st;
    a1_nxt.en   = in_en;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_vld_r <= 1'b0;
    end else begin
      a1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    a1_r     <= a1_nxt;
    a1_num_r <= e1 ? scqc_pkg::NUM_W'(mag1) * scqc_pkg::NUM_W'(d1[16:0]) : '0;
  end

  logic                       q1_vld;
  logic [scqc_pkg::NUM_W-1:0] q1;
  logic [SW-1:0]              q1_side;
  scqc_pkg::edge_side_t       s1;

  scqc_div #(.SIDE_W(SW)) u_div_near (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (a1_vld_r),
    .in_num   (a1_num_r),
    .in_div   (a1_r.size[14:0]),
    .in_side  (a1_r),
    .out_vld  (q1_vld),
    .out_quo  (q1),
    .out_side (q1_side)
  );

  assign s1 = scqc_pkg::edge_side_t'(q1_side);

  // near edge update
  logic signed [35:0]   qs1;
  logic                 a2_vld_r;
  scqc_pkg::edge_side_t a2_r;
  scqc_pkg::edge_side_t a2_nxt;

  assign qs1 = s1.neg ? -$signed({2'b00, q1}) : $signed({2'b00, q1});

  always_comb begin
    a2_nxt = s1;
    if (s1.clip) begin
      a2_nxt.st   = scqc_pkg::sat16($signed({{20{s1.st[15]}}, s1.st}) + qs1);
      a2_nxt.size = s1.size - s1.d;
      a2_nxt.pos  = cfg.lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a2_vld_r <= 1'b0;
    end else begin
      a2_vld_r <= q1_vld;
    end
  end

  always_ff @(posedge clk) begin
    a2_r <= a2_nxt;
  end

  // far edge setup
  logic signed [19:0]         far;
  logic signed [19:0]         d2;
  logic signed [16:0]         sp2;
  logic [16:0]                mag2;
  logic                       e2;
  logic                       a3_vld_r;
  logic [scqc_pkg::NUM_W-1:0] a3_num_r;
  scqc_pkg::edge_side_t       a3_r;
  scqc_pkg::edge_side_t       a3_nxt;

  assign far  = $signed({{4{cfg.lo[15]}}, cfg.lo}) + $signed({5'd0, cfg.len});
  assign d2   = $signed({{4{a2_r.pos[15]}}, a2_r.pos})
              + $signed({{2{a2_r.size[17]}}, a2_r.size}) - far;
  assign e2   = cfg.on && (d2 > 20'sd0) && (a2_r.size > 18'sd0);
  assign sp2  = $signed({a2_r.en[15], a2_r.en}) - $signed({a2_r.st[15], a2_r.st});
  assign mag2 = sp2[16] ? 17'(-sp2) : 17'(sp2);

  always_comb begin
    a3_nxt      = a2_r;
    a3_nxt.neg  = sp2[16];
    a3_nxt.clip = e2;
    a3_nxt.d    = 18'(d2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a3_vld_r <= 1'b0;
    end else begin
      a3_vld_r <= a2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a3_r     <= a3_nxt;
    a3_num_r <= e2 ? scqc_pkg::NUM_W'(mag2) * scqc_pkg::NUM_W'(d2[16:0]) : '0;
  end

  logic                       q2_vld;
  logic [scqc_pkg::NUM_W-1:0] q2;
  logic [SW-1:0]              q2_side;
  scqc_pkg::edge_side_t       s2;

  scqc_div #(.SIDE_W(SW)) u_div_far (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (a3_vld_r),
    .in_num   (a3_num_r),
    .in_div   (a3_r.size[14:0]),
    .in_side  (a3_r),
    .out_vld  (q2_vld),
    .out_quo  (q2),
    .out_side (q2_side)
  );

  assign s2 = scqc_pkg::edge_side_t'(q2_side);

  // far edge update
  logic signed [35:0]   qs2;
  logic                 a4_vld_r;
  scqc_pkg::edge_side_t a4_r;
  scqc_pkg::edge_side_t a4_nxt;

  assign qs2 = s2.neg ? -$signed({2'b00, q2}) : $signed({2'b00, q2});

  always_comb begin
    a4_nxt = s2;
    if (s2.clip) begin
      a4_nxt.en   = scqc_pkg::sat16($signed({{20{s2.en[15]}}, s2.en}) - qs2);
      a4_nxt.size = s2.size - s2.d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a4_vld_r <= 1'b0;
    end else begin
      a4_vld_r <= q2_vld;
    end
  end

  always_ff @(posedge clk) begin
    a4_r <= a4_nxt;
  end

  assign out_vld  = a4_vld_r;
  assign out_pos  = a4_r.pos;
  assign out_size = a4_r.size;
  assign out_st   = a4_r.st;
  assign out_en   = a4_r.en;

endmodule

// ===== rtl/scissor_quad_clip_uv.sv =====
// top level: scissor clip of a textured rectangle, emitting four fp16-textured vertices
// the first vertex passes the input register, both axis pipelines, the corner register
// and the emission register; the other three corners follow it in TL, BL, BR, TR order
// throughput is set by the single vertex output: busy stays high after each accepted
// transaction while a down-counter runs out, so a new rectangle may enter before earlier ones leave
// reset clears the scissor registers (clipping off) and all valid bits
module scissor_quad_clip_uv (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_rect_w,
  input  logic signed [15:0] in_rect_h,
  input  logic signed [15:0] in_tex_s_start,
  input  logic signed [15:0] in_tex_t_start,
  input  logic signed [15:0] in_tex_s_end,
  input  logic signed [15:0] in_tex_t_end,
  input  logic [31:0]        in_rgba,
  output logic               out_valid,
  output logic [1:0]         out_corner,
  output logic signed [15:0] out_vert_x,
  output logic signed [15:0] out_vert_y,
  output logic [15:0]        out_vert_s_half,
  output logic [15:0]        out_vert_t_half,
  output logic [31:0]        out_vert_rgba,
  output logic               out_last_corner,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata
);

  localparam int LAT = scqc_pkg::AXIS_LAT;

  // configuration
  logic signed [15:0] clip_left_r;
  logic signed [15:0] clip_top_r;
  logic [14:0]        clip_width_r;
  logic [14:0]        clip_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= '0;
      clip_top_r    <= '0;
      clip_width_r  <= '0;
      clip_height_r <= '0;
    end else if (cfg_we) begin
      case (scqc_pkg::cfg_reg_t'(cfg_addr))
        scqc_pkg::REG_CLIP_LEFT:   clip_left_r   <= cfg_wdata;
        scqc_pkg::REG_CLIP_TOP:    clip_top_r    <= cfg_wdata;
        scqc_pkg::REG_CLIP_WIDTH:  clip_width_r  <= cfg_wdata[14:0];
        scqc_pkg::REG_CLIP_HEIGHT: clip_height_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  logic                clip_on;
  scqc_pkg::axis_cfg_t cfg_x;
  scqc_pkg::axis_cfg_t cfg_y;

  assign clip_on = (clip_width_r != '0) && (clip_height_r != '0);
  assign cfg_x   = '{on: clip_on, lo: clip_left_r, len: clip_width_r};
  assign cfg_y   = '{on: clip_on, lo: clip_top_r, len: clip_height_r};

  // accept and input register
  logic [1:0] gap_r;
  logic       accept;

  assign busy   = (gap_r != 2'd0);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= 2'd0;
    end else if (accept) begin
      gap_r <= 2'd3;
    end else if (busy) begin
      gap_r <= gap_r - 2'd1;
    end
  end

  logic               v0_r;
  logic signed [15:0] x0_r, y0_r, w0_r, h0_r, s1_0_r, t1_0_r, s2_0_r, t2_0_r;
  logic [31:0]        rgba0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept && (in_rect_w > 16'sd0) && (in_rect_h > 16'sd0);
    end
  end

  always_ff @(posedge clk) begin
    x0_r    <= in_pos_x;
    y0_r    <= in_pos_y;
    w0_r    <= in_rect_w;
    h0_r    <= in_rect_h;
    s1_0_r  <= in_tex_s_start;
    t1_0_r  <= in_tex_t_start;
    s2_0_r  <= in_tex_s_end;
    t2_0_r  <= in_tex_t_end;
    rgba0_r <= in_rgba;
  end

  // the two axes
  logic               vx, vy;
  logic signed [15:0] xc, yc, sc1, sc2, tc1, tc2;
  logic signed [17:0] wc, hc;

  scqc_axis u_axis_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_x),
    .in_vld   (v0_r),
    .in_pos   (x0_r),
    .in_size  (w0_r),
    .in_st    (s1_0_r),
    .in_en    (s2_0_r),
    .out_vld  (vx),
    .out_pos  (xc),
    .out_size (wc),
    .out_st   (sc1),
    .out_en   (sc2)
  );

  scqc_axis u_axis_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_y),
    .in_vld   (v0_r),
    .in_pos   (y0_r),
    .in_size  (h0_r),
    .in_st    (t1_0_r),
    .in_en    (t2_0_r),
    .out_vld  (vy),
    .out_pos  (yc),
    .out_size (hc),
    .out_st   (tc1),
    .out_en   (tc2)
  );

  // color delay line matching the axis pipeline
  logic [31:0] rgba_d_r [LAT];

  always_ff @(posedge clk) begin
    rgba_d_r[0] <= rgba0_r;
    for (int i = 1; i < LAT; i++) begin
      rgba_d_r[i] <= rgba_d_r[i-1];
    end
  end

  // corner positions and fp16 texture coordinates
  logic               vf_r;
  logic signed [15:0] xa_r, xb_r, ya_r, yb_r;
  logic [15:0]        hs1_r, hs2_r, ht1_r, ht2_r;
  logic [31:0]        rgbaf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else begin
      vf_r <= vx && vy && (wc > 18'sd0) && (hc > 18'sd0);
    end
  end

  always_ff @(posedge clk) begin
    xa_r    <= xc;
    ya_r    <= yc;
    xb_r    <= scqc_pkg::sat16($signed({{20{xc[15]}}, xc}) + $signed({{18{wc[17]}}, wc}));
    yb_r    <= scqc_pkg::sat16($signed({{20{yc[15]}}, yc}) + $signed({{18{hc[17]}}, hc}));
    hs1_r   <= scqc_pkg::to_half(sc1);
    hs2_r   <= scqc_pkg::to_half(sc2);
    ht1_r   <= scqc_pkg::to_half(tc1);
    ht2_r   <= scqc_pkg::to_half(tc2);
    rgbaf_r <= rgba_d_r[LAT-1];
  end

  // vertex emission
  logic               act_r;
  logic [1:0]         cnt_r;
  logic signed [15:0] qxa_r, qxb_r, qya_r, qyb_r;
  logic [15:0]        qs1_r, qs2_r, qt1_r, qt2_r;
  logic [31:0]        qrgba_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= 2'd0;
    end else if (vf_r) begin
      act_r <= 1'b1;
      cnt_r <= 2'd0;
    end else if (act_r) begin
      act_r <= (cnt_r != 2'd3);
      cnt_r <= cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (vf_r) begin
      qxa_r   <= xa_r;
      qxb_r   <= xb_r;
      qya_r   <= ya_r;
      qyb_r   <= yb_r;
      qs1_r   <= hs1_r;
      qs2_r   <= hs2_r;
      qt1_r   <= ht1_r;
      qt2_r   <= ht2_r;
      qrgba_r <= rgbaf_r;
    end
  end

  always_comb begin
    out_vert_x      = qxa_r;
    out_vert_y      = qya_r;
    out_vert_s_half = qs1_r;
    out_vert_t_half = qt1_r;
    case (scqc_pkg::corner_t'(cnt_r))
      scqc_pkg::CORNER_TL: begin
        out_vert_x      = qxa_r;
        out_vert_y      = qya_r;
        out_vert_s_half = qs1_r;
        out_vert_t_half = qt1_r;
      end
      scqc_pkg::CORNER_BL: begin
        out_vert_x      = qxa_r;
        out_vert_y      = qyb_r;
        out_vert_s_half = qs1_r;
        out_vert_t_half = qt2_r;
      end
      scqc_pkg::CORNER_BR: begin
        out_vert_x      = qxb_r;
        out_vert_y      = qyb_r;
        out_vert_s_half = qs2_r;
        out_vert_t_half = qt2_r;
      end
      scqc_pkg::CORNER_TR: begin
        out_vert_x      = qxb_r;
        out_vert_y      = qya_r;
        out_vert_s_half = qs2_r;
        out_vert_t_half = qt1_r;
      end
      default: ;
    endcase
  end

  assign out_valid       = act_r;
  assign out_corner      = cnt_r;
  assign out_vert_rgba   = qrgba_r;
  assign out_last_corner = (scqc_pkg::corner_t'(cnt_r) == scqc_pkg::CORNER_TR);

endmodule
